@@ rtl/sida_pkg.sv @@
// Shared types and constants for the signed integer to decimal text converter.
package sida_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  // A 32-bit magnitude never needs more than ten decimal digits.
  localparam int FULL_DIGITS = 10;
  localparam int STEP_CNT_W  = 5;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(VALUE_W - 1);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

  typedef struct packed {
    logic load;
    logic shift;
    logic dec_idx;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic digit_zero;
    logic idx_zero;
    logic ovf;
    logic neg;
    logic emit_ok;
  } sts_t;

endpackage

@@ rtl/sida_dp.sv @@
// Datapath: magnitude, shift-and-add-3 BCD register, digit pointer and output register.
module sida_dp #(
  parameter int NUM_DIGITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [sida_pkg::VALUE_W-1:0] value,
  input  sida_pkg::cmd_t                cmd,
  output sida_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sida_pkg::CHAR_W-1:0]   character,
  output logic                          last
);
  import sida_pkg::*;

  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(NUM_DIGITS - 1);

  logic [VALUE_W-1:0]    mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_corr;
  logic [STEP_CNT_W-1:0] step;
  logic [IDX_W-1:0]      idx;
  logic                  neg;
  logic                  ovf;
  logic [3:0]            cur_digit;

  // Add 3 to every digit of five or more so the following shift doubles in decimal.
  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[i*4 +: 4];
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      bcd_corr[i*4 +: 4] = d;
    end
  end

  assign cur_digit = bcd[idx*4 +: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg  <= value[VALUE_W-1];
      mag  <= value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(value)) : $unsigned(value);
      bcd  <= '0;
      ovf  <= 1'b0;
      step <= '0;
      idx  <= TOP_IDX;
    end else begin
      if (cmd.shift) begin
        bcd  <= {bcd_corr[BCD_W-2:0], mag[VALUE_W-1]};
        mag  <= {mag[VALUE_W-2:0], 1'b0};
        step <= step + STEP_CNT_W'(1);
        // A bit leaving the top digit means the magnitude has more digits than the buffer.
        if (bcd_corr[BCD_W-1]) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.dec_idx) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= CH_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= CH_ZERO + {4'b0000, cur_digit};
      last      <= (idx == '0);
    end
  end

  always_comb begin
    sts.conv_done  = (step == LAST_STEP);
    sts.digit_zero = (cur_digit == 4'd0);
    sts.idx_zero   = (idx == '0);
    sts.ovf        = ovf;
    sts.neg        = neg;
    sts.emit_ok    = !out_valid || out_ready;
  end

endmodule

@@ rtl/sida_ctrl.sv @@
// Controller: sequences load, conversion, leading-zero skip and character output.
module sida_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sida_pkg::sts_t sts,
  output sida_pkg::cmd_t cmd
);
  import sida_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SKIP  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_done) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // Leading zeros are printed only when the magnitude overran the buffer.
        if (!sts.ovf && !sts.idx_zero && sts.digit_zero) begin
          cmd.dec_idx = 1'b1;
        end else begin
          state_next = sts.neg ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (sts.emit_ok) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts.emit_ok) begin
          cmd.emit_digit = 1'b1;
          if (sts.idx_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.dec_idx = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Each accepted transaction carries one signed 32-bit value; the block returns its decimal
// text one character per output transaction, most significant first, with a leading '-'
// for negative values, no leading zeros, "0" for zero, and last set on the final
// character. One number occupies the block while it is loaded, put through the 32 one-bit
// shift-and-correct steps of the binary-to-BCD converter, cleared of leading zeros and
// sent. Skipped zeros and sent digits together always number min(MAX_DIGITS, 10). The next
// number is accepted as soon as the final character sits in the output register.
// MAX_DIGITS limits the digits kept: a larger magnitude is sent as its MAX_DIGITS least
// significant digits, zeros included.
module signed_int_to_decimal_ascii_top #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sida_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sida_pkg::CHAR_W-1:0]         character,
  output logic                                last
);
  import sida_pkg::*;

  localparam int NUM_DIGITS = (MAX_DIGITS < FULL_DIGITS) ? MAX_DIGITS : FULL_DIGITS;

  cmd_t cmd;
  sts_t sts;

  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sida_dp #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

endmodule

@@ rtl/sida_checker.sv @@
// Port-level assertions for the decimal text converter and their bind to the top level.
module sida_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sida_pkg::CHAR_W-1:0] character,
  input logic                        last
);
  import sida_pkg::*;

  // A stalled output transaction keeps its character and flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("output changed while stalled");

  // Only a minus sign or a decimal digit is ever sent.
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CH_MINUS) || ((character >= CH_ZERO) && (character <= CH_NINE)))
    else $error("character outside the decimal text set");

  // A minus sign always has digits after it.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (character == CH_MINUS) |-> !last)
    else $error("minus sign flagged as last");

  // After a number is taken the block is busy converting it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

endmodule

bind signed_int_to_decimal_ascii_top sida_checker u_sida_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .character (character),
  .last      (last)
);

@@ tb/signed_int_to_decimal_ascii_top_tb.sv @@
// Testbench for the signed integer to decimal ASCII text converter.
module signed_int_to_decimal_ascii_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sida_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } text_char_t;

  // Holds the characters still owed by the block and checks each one as it leaves.
  class decimal_text_board #(int DIGIT_LIMIT = 10);
    text_char_t pending_text[$];
    int         failures;

    function new();
      failures = 0;
    endfunction

    // Renders one accepted number and queues its characters.
    function void note_number(logic signed [VALUE_W-1:0] num);
      logic [VALUE_W-1:0] mag;
      logic [3:0]         digs[20];
      int                 nd;
      text_char_t         c;
      nd = 0;
      // Taking the magnitude modulo 2^32 makes the most negative value come out right.
      mag = num[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(num)) : VALUE_W'(num);
      if (mag == 0) begin
        c.ch = CH_ZERO;
        c.fin = 1'b1;
        pending_text.push_back(c);
        return;
      end
      while (mag != 0 && nd < DIGIT_LIMIT) begin
        digs[nd] = 4'(mag % 10);
        mag = mag / 10;
        nd++;
      end
      if (num[VALUE_W-1]) begin
        c.ch = CH_MINUS;
        c.fin = 1'b0;
        pending_text.push_back(c);
      end
      for (int i = nd - 1; i >= 0; i--) begin
        c.ch = CH_ZERO + CHAR_W'(digs[i]);
        c.fin = (i == 0);
        pending_text.push_back(c);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic fin, time stamp);
      text_char_t want;
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual 0x%02h last=%0b",
                 stamp, ch, fin);
        failures++;
        return;
      end
      want = pending_text.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: character mismatch: expected 0x%02h, actual 0x%02h",
                 stamp, want.ch, ch);
        failures++;
      end
      if (fin !== want.fin) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", stamp, want.fin, fin);
        failures++;
      end
    endfunction

    function int outstanding();
      return pending_text.size();
    endfunction
  endclass

  localparam int DIGIT_LIMIT = 10;
  localparam int RANDOM_NUMBERS = 76;
  localparam int HOLD_START = 1500;
  localparam int HOLD_CYCLES = 400;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] value;
  logic                      out_valid;
  logic                      out_ready;
  logic [CHAR_W-1:0]         character;
  logic                      last;

  decimal_text_board #(DIGIT_LIMIT) board;

  signed_int_to_decimal_ascii_top #(
    .MAX_DIGITS(DIGIT_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .character(character),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Mostly picks a digit count first so that short and long numbers are equally common.
  function automatic logic signed [VALUE_W-1:0] random_number();
    int                 ndig;
    longint             lo;
    longint             hi;
    logic [VALUE_W-1:0] mag;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return VALUE_W'($urandom_range(0, 20)) - VALUE_W'(10);
      default: begin
        ndig = $urandom_range(1, FULL_DIGITS);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'd2147483648) hi = 64'd2147483648;
        mag = VALUE_W'(lo) + $urandom_range(0, 32'(hi - lo));
        return $urandom_range(0, 1) ? (VALUE_W'(0) - mag) : mag;
      end
    endcase
  endfunction

  task automatic send_number(input logic signed [VALUE_W-1:0] num);
    int gap;
    in_valid <= 1'b1;
    value <= num;
    do @(posedge clk); while (!in_ready);
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Both handshakes are observed at the edge, before any nonblocking update lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_number(value);
      if (out_valid && out_ready) board.check_char(character, last, $time);
    end
  end

  // Receiver: random runs and stalls, plus one long hold-off that backs up the input.
  initial begin
    int run_left;
    int stall_left;
    int cycle;
    run_left = 0;
    stall_left = 0;
    cycle = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle == HOLD_START) begin
        run_left = 0;
        stall_left = HOLD_CYCLES;
      end
      if (run_left == 0 && stall_left == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          run_left = $urandom_range(50, 150);
        end else begin
          run_left = $urandom_range(1, 24);
          stall_left = idle_cycles();
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        run_left--;
      end
    end
  end

  initial begin
    logic signed [VALUE_W-1:0] corner_values[$];
    corner_values = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100, -32'sd100,
      32'sd7, -32'sd5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 32'sh7FFF_FFFE,
      32'sd1000000000, 32'sd999999999, -32'sd999999999, 32'sd1234567890,
      -32'sd1234567890, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1000000, -32'sd2000000001
    };
    board = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_values[i]) send_number(corner_values[i]);
    repeat (RANDOM_NUMBERS) send_number(random_number());
    in_valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    // Leave room for any stray character the block might still send.
    repeat (60) @(posedge clk);
    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("signed_int_to_decimal_ascii_top_tb: PASS");
    end else begin
      $display("signed_int_to_decimal_ascii_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("signed_int_to_decimal_ascii_top_tb: FAIL");
    $finish;
  end
endmodule
